### design/mpjq_pkg.sv
`timescale 1ns / 1ps

package mpjq_pkg;

	typedef enum logic [1:0] {
		FUNC_ENQ  = 2'd0,
		FUNC_DEQ  = 2'd1,
		FUNC_PEEK = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] job_priority;
		logic [31:0] job_pid;
		logic [31:0] job_ident;
	} job_req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_priority;
		logic [31:0] out_pid;
		logic [31:0] out_ident;
		logic [4:0]  occupancy;
	} job_rsp_t;

	// One job slot. A priority of zero marks the slot as free.
	typedef struct packed {
		logic [15:0] pri;
		logic [31:0] pid;
		logic [31:0] ident;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_cmd_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		cell_cmd_t cmd;
		entry_t    ins;
	} cell_ctrl_t;

endpackage

### design/mpjq_cell.sv
`timescale 1ns / 1ps

module mpjq_cell
	import mpjq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     left_slot,
	input  logic       left_keep,
	input  entry_t     right_slot,
	output entry_t     slot,
	output logic       keep
);

	entry_t slot_q;
	entry_t slot_d;

	// A cell keeps its job on insert when it holds one at least as urgent as the
	// new job; the kept cells form a prefix of the chain, so order stays stable.
	assign keep = (slot_q.pri != 16'd0) && (slot_q.pri <= ctrl.ins.pri);
	assign slot = slot_q;

	always_comb begin
		slot_d = slot_q;
		case (ctrl.cmd)
			CELL_INSERT: begin
				if (!keep) begin
					slot_d = left_keep ? ctrl.ins : left_slot;
				end
			end
			CELL_SHIFT: slot_d = right_slot;
			default: slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule

### design/min_priority_job_queue_unit.sv
`timescale 1ns / 1ps
// A result appears on rsp with done high in the cycle after its item is accepted.
// Throughput: one item per cycle while busy is low; all cells of the sorted chain update together.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset (arst_n low) empties the queue at once; busy stays high for the first cycle
// after reset is released and is low from then on.
module min_priority_job_queue_unit
	import mpjq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  job_req_t req,
	output logic     done,
	output job_rsp_t rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// The queue is a chain of cells kept sorted by priority, with jobs of equal
	// priority in arrival order. The head cell therefore always holds the most
	// urgent job, the earliest of those that share its priority. Enqueue
	// inserts in place by shifting the less urgent tail right one cell; dequeue
	// shifts the whole chain left one cell.

	logic          busy_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          done_q;
	job_rsp_t      rsp_q;
	job_rsp_t      rsp_d;
	cell_ctrl_t    ctrl;
	entry_t        slot_w [QUEUE_DEPTH];
	logic          keep_w [QUEUE_DEPTH];
	logic          accept;
	logic          full;
	logic          empty;
	logic [CW+4:0] count_ext;

	assign accept = start && !busy_q;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			entry_t left_slot;
			logic   left_keep;
			entry_t right_slot;

			if (gi == 0) begin : g_first
				// The head has no left neighbor: unless it keeps its job, it takes the new one.
				assign left_slot = ctrl.ins;
				assign left_keep = 1'b1;
			end else begin : g_mid
				assign left_slot = slot_w[gi-1];
				assign left_keep = keep_w[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				// The tail fills with a free slot when the chain shifts left.
				assign right_slot = '0;
			end else begin : g_inner
				assign right_slot = slot_w[gi+1];
			end

			mpjq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.left_slot  (left_slot),
				.left_keep  (left_keep),
				.right_slot (right_slot),
				.slot       (slot_w[gi]),
				.keep       (keep_w[gi])
			);
		end
	endgenerate

	// Occupancy is reported in five bits, whatever the depth.
	assign count_ext = {5'd0, count_q};

	// Decode the accepted item into a chain command and its response.
	always_comb begin
		ctrl.cmd       = CELL_HOLD;
		ctrl.ins.pri   = req.job_priority;
		ctrl.ins.pid   = req.job_pid;
		ctrl.ins.ident = req.job_ident;
		count_d        = count_q;
		rsp_d          = '0;
		rsp_d.status   = ST_OK;
		if (accept) begin
			unique case (req.func)
				FUNC_ENQ: begin
					// The full check comes before the zero-priority check.
					if (full) begin
						rsp_d.status = ST_FULL;
					end else if (req.job_priority == 16'd0) begin
						rsp_d.status = ST_ZERO;
					end else begin
						ctrl.cmd = CELL_INSERT;
						count_d  = count_q + CW'(1);
					end
				end
				FUNC_DEQ, FUNC_PEEK: begin
					if (empty) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						rsp_d.out_priority = slot_w[0].pri;
						rsp_d.out_pid      = slot_w[0].pid;
						rsp_d.out_ident    = slot_w[0].ident;
						if (req.func == FUNC_DEQ) begin
							ctrl.cmd = CELL_SHIFT;
							count_d  = count_q - CW'(1);
						end
					end
				end
				// The unused code does nothing and reports status ok.
				default: rsp_d.status = ST_OK;
			endcase
		end
		rsp_d.occupancy = 5'({5'd0, count_d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// A result is shown only for an item accepted in the cycle before.
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result strobe without an accepted item");

	// The head cell holds a job exactly when the count is nonzero.
	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) == (slot_w[0].pri != 16'd0))
		else $error("head cell disagrees with the entry count");

	// The first two cells stay in priority order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_w[1].pri == 16'd0) || ((slot_w[0].pri != 16'd0)
		&& (slot_w[0].pri <= slot_w[1].pri)))
		else $error("chain head out of priority order");

	// An empty report always comes with zero occupancy.
	a_empty_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_EMPTY)) |-> (rsp.occupancy == 5'd0))
		else $error("empty status with nonzero occupancy");

	// Occupancy tracks the internal count.
	a_occupancy_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.occupancy == count_ext[4:0]))
		else $error("reported occupancy differs from count");

endmodule
